/* rtl/c8ic_pkg.sv */
// Package for the CHIP-8 instruction core: constants, codes, font table,
// controller/datapath command and status structs. No dependencies.
package c8ic_pkg;

   localparam int DisplayWidthDefault  = 64;
   localparam int DisplayHeightDefault = 32;
   localparam int MemDepthDefault      = 4096;
   localparam int StackDepthDefault    = 16;

   localparam int ADDR_W  = 12;
   localparam int ROW_W   = 64;
   localparam int FONT_N  = 80;

   localparam logic [ADDR_W-1:0] RESET_START = 12'h200;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_EXEC  = 2'd1;
   localparam logic [1:0] ACT_ROW   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_UNIMPL    = 2'd3;

   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_CALL = 4'h2;
   localparam logic [3:0] OP_SETV = 4'h6;
   localparam logic [3:0] OP_SETI = 4'hA;
   localparam logic [3:0] OP_DRAW = 4'hD;
   localparam logic [11:0] NNN_CLS = 12'h0E0;
   localparam logic [11:0] NNN_RET = 12'h0EE;

   // datapath commands issued by the controller
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_MEM_WRITE,   // store item byte
      CMD_FETCH_HI,    // read memory at pc
      CMD_FETCH_LO,    // latch hi byte, read memory at pc+1
      CMD_DECODE,      // latch opcode, advance pc
      CMD_EXECUTE,     // simple ops, draw setup
      CMD_CLEAR_ROW,   // clear row at counter
      CMD_DRAW_READ,   // read sprite byte and frame row
      CMD_DRAW_WRITE,  // xor row back
      CMD_ROW_READ,    // read display row
      CMD_RESPOND      // drive result
   } cmd_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [1:0]       status;
   } ctl_type;

   typedef struct packed {
      logic [3:0]  op_class;
      logic [11:0] nnn;
      logic        stack_full;
      logic        stack_empty;
      logic        clear_last;
      logic        draw_last;
   } sts_type;

   function automatic logic [7:0] font_byte(input logic [6:0] idx);
      logic [7:0] glyphs [0:FONT_N-1];
      glyphs = '{
         8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
         8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
         8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
         8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
         8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
         8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
         8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
         8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
      return (idx < 7'(FONT_N)) ? glyphs[idx] : 8'h00;
   endfunction

endpackage

/* rtl/c8ic_controller.sv */
// Controller state machine of the CHIP-8 instruction core.
// Depends on c8ic_pkg; sequences the datapath by command and status structs.
module c8ic_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         action,
   input  c8ic_pkg::sts_type  sts,
   output c8ic_pkg::ctl_type  ctl,
   output logic               busy
);
   import c8ic_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_EXECUTE,
      S_CLEAR, S_DRAW_READ, S_DRAW_WRITE, S_ROW, S_RESPOND
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;

   // next state and status
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: begin
            status_in = ST_OK;
            if (start) begin
               if (action == ACT_EXEC) state_in = S_FETCH_HI;
               else if (action == ACT_ROW) state_in = S_ROW;
               else state_in = S_RESPOND;
            end
         end
         S_FETCH_HI: state_in = S_FETCH_LO;
         S_FETCH_LO: state_in = S_DECODE;
         S_DECODE:   state_in = S_EXECUTE;
         S_EXECUTE: begin
            state_in = S_RESPOND;
            case (sts.op_class)
               OP_SYS: begin
                  if (sts.nnn == NNN_CLS) state_in = S_CLEAR;
                  else if (sts.nnn == NNN_RET) begin
                     if (sts.stack_empty) status_in = ST_UNDERFLOW;
                  end else status_in = ST_UNIMPL;
               end
               OP_CALL: if (sts.stack_full) status_in = ST_OVERFLOW;
               OP_SETV, OP_SETI: ;
               OP_DRAW: if (!sts.draw_last) state_in = S_DRAW_READ;
               default: status_in = ST_UNIMPL;
            endcase
         end
         S_CLEAR:      if (sts.clear_last) state_in = S_RESPOND;
         S_DRAW_READ:  state_in = S_DRAW_WRITE;
         S_DRAW_WRITE: state_in = sts.draw_last ? S_RESPOND : S_DRAW_READ;
         S_ROW:        state_in = S_RESPOND;
         S_RESPOND:    state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   // decode commands
   always_comb begin
      ctl.status = status_ff;
      case (state_ff)
         S_IDLE:       ctl.cmd = (start && action == ACT_WRITE) ? CMD_MEM_WRITE : CMD_NONE;
         S_FETCH_HI:   ctl.cmd = CMD_FETCH_HI;
         S_FETCH_LO:   ctl.cmd = CMD_FETCH_LO;
         S_DECODE:     ctl.cmd = CMD_DECODE;
         S_EXECUTE:    ctl.cmd = CMD_EXECUTE;
         S_CLEAR:      ctl.cmd = CMD_CLEAR_ROW;
         S_DRAW_READ:  ctl.cmd = CMD_DRAW_READ;
         S_DRAW_WRITE: ctl.cmd = CMD_DRAW_WRITE;
         S_ROW:        ctl.cmd = CMD_ROW_READ;
         S_RESPOND:    ctl.cmd = CMD_RESPOND;
         default:      ctl.cmd = CMD_NONE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* rtl/c8ic_datapath.sv */
// Datapath of the CHIP-8 instruction core: memory, frame, stack, registers.
// Depends on c8ic_pkg; driven by commands from c8ic_controller.
module c8ic_datapath #(
   parameter int DISPLAY_WIDTH  = c8ic_pkg::DisplayWidthDefault,
   parameter int DISPLAY_HEIGHT = c8ic_pkg::DisplayHeightDefault,
   parameter int MEM_DEPTH      = c8ic_pkg::MemDepthDefault,
   parameter int STACK_DEPTH    = c8ic_pkg::StackDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_action,
   input  logic [11:0]        req_address,
   input  logic [7:0]         req_data,
   input  logic               csr_write,
   input  logic [11:0]        csr_data,
   input  c8ic_pkg::ctl_type  ctl,
   output c8ic_pkg::sts_type  sts,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_fetched_opcode,
   output logic [11:0]        rsp_next_pc,
   output logic               rsp_collision,
   output logic [63:0]        rsp_row_bits
);
   import c8ic_pkg::*;

   localparam int MA_W = $clog2(MEM_DEPTH);
   localparam int RY_W = $clog2(DISPLAY_HEIGHT);
   localparam int CX_W = $clog2(DISPLAY_WIDTH);
   localparam int SP_W = $clog2(STACK_DEPTH);
   localparam int LV_W = $clog2(STACK_DEPTH + 1);
   localparam logic [ROW_W-1:0] COL_MASK = ~({ROW_W{1'b1}} >> DISPLAY_WIDTH);

   // storage
   logic [7:0]        mem [0:MEM_DEPTH-1];
   logic [ROW_W-1:0]  frame [0:DISPLAY_HEIGHT-1];
   logic [11:0]       stack [0:STACK_DEPTH-1];
   logic [7:0]        vreg_ff [0:15];
   logic              fvalid_ff [0:DISPLAY_HEIGHT-1];

   logic [LV_W-1:0]   level_ff;
   logic [11:0]       index_ff, pc_ff;
   logic [11:0]       addr_ff;
   logic [1:0]        act_ff;
   logic [7:0]        hi_ff, rd_ff;
   logic [15:0]       op_ff;
   logic [RY_W:0]     cnt_ff;      // clear row counter
   logic [3:0]        left_ff;     // sprite rows remaining
   logic [CX_W-1:0]   x0_ff;
   logic [RY_W-1:0]   y_ff;
   logic [11:0]       sa_ff;
   logic [ROW_W-1:0]  frow_ff;

   // memory clearing pass: fills font/zero after reset
   logic              init_ff;
   logic [MA_W:0]     init_cnt_ff;

   logic [11:0] mem_addr;
   logic        mem_in_range;

   // memory read address by command
   always_comb begin
      case (ctl.cmd)
         CMD_FETCH_HI:  mem_addr = pc_ff;
         CMD_FETCH_LO:  mem_addr = pc_ff + 12'd1;
         default:       mem_addr = sa_ff;
      endcase
   end
   assign mem_in_range = ({1'b0, mem_addr} < 13'(MEM_DEPTH));

   // memory: one write port, one registered read
   always_ff @(posedge clock) begin
      if (init_ff)
         mem[init_cnt_ff[MA_W-1:0]] <= font_byte(7'(init_cnt_ff < (MA_W+1)'(FONT_N)
                                        ? init_cnt_ff : '0)) & {8{init_cnt_ff < (MA_W+1)'(FONT_N)}};
      else if (ctl.cmd == CMD_MEM_WRITE && {1'b0, req_address} < 13'(MEM_DEPTH))
         mem[req_address[MA_W-1:0]] <= req_data;
      rd_ff <= mem_in_range ? mem[mem_addr[MA_W-1:0]] : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff     <= 1'b1;
         init_cnt_ff <= '0;
      end else if (init_ff) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
         if (init_cnt_ff == (MA_W+1)'(MEM_DEPTH - 1)) init_ff <= 1'b0;
      end
   end

   // status to controller; a draw with zero rows ends at execute
   assign sts.op_class    = op_ff[15:12];
   assign sts.nnn         = op_ff[11:0];
   assign sts.stack_full  = (level_ff == LV_W'(STACK_DEPTH));
   assign sts.stack_empty = (level_ff == '0);
   assign sts.clear_last  = (cnt_ff == (RY_W+1)'(DISPLAY_HEIGHT - 1));
   assign sts.draw_last   = (ctl.cmd == CMD_EXECUTE) ? (op_ff[3:0] == 4'd0) :
                            ((left_ff == 4'd0) ||
                             ({1'b0, y_ff} == (RY_W+1)'(DISPLAY_HEIGHT)) ||
                             (ctl.cmd == CMD_DRAW_WRITE &&
                              ({1'b0, y_ff} == (RY_W+1)'(DISPLAY_HEIGHT - 1) ||
                               left_ff == 4'd1)));

   // xor mask for the current sprite row
   logic [ROW_W-1:0] spr_mask, cur_row;
   always_comb begin
      spr_mask = ({rd_ff, {(ROW_W-8){1'b0}}} >> x0_ff) & COL_MASK;
      cur_row  = fvalid_ff[y_ff] ? frow_ff : '0;
   end

   // frame row read and write
   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_DRAW_READ) frow_ff <= frame[y_ff];
      else if (ctl.cmd == CMD_ROW_READ) frow_ff <= frame[addr_ff[RY_W-1:0]];
      if (ctl.cmd == CMD_DRAW_WRITE) frame[y_ff] <= cur_row ^ spr_mask;
   end

   // call stack storage
   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_EXECUTE && op_ff[15:12] == OP_CALL && !sts.stack_full)
         stack[level_ff[SP_W-1:0]] <= pc_ff;
   end

   // architectural registers and sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         index_ff <= '0;
         pc_ff    <= RESET_START;
         sa_ff    <= '0;
         for (int i = 0; i < 16; i++) vreg_ff[i] <= 8'h00;
         for (int r = 0; r < DISPLAY_HEIGHT; r++) fvalid_ff[r] <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_write) pc_ff <= csr_data;
         if (start && !busy) begin
            addr_ff <= req_address;
            act_ff  <= req_action;
            op_ff   <= 16'h0000;
            cnt_ff  <= '0;
         end
         case (ctl.cmd)
            CMD_FETCH_LO: hi_ff <= rd_ff;
            CMD_DECODE: begin
               op_ff <= {hi_ff, rd_ff};
               pc_ff <= pc_ff + 12'd2;
            end
            CMD_EXECUTE: begin
               case (op_ff[15:12])
                  OP_SYS: if (op_ff[11:0] == NNN_RET && level_ff != '0) begin
                     level_ff <= level_ff - 1'b1;
                     pc_ff    <= stack[SP_W'(level_ff - 1'b1)];
                  end
                  OP_CALL: if (!sts.stack_full) begin
                     level_ff <= level_ff + 1'b1;
                     pc_ff    <= op_ff[11:0];
                  end
                  OP_SETV: vreg_ff[op_ff[11:8]] <= op_ff[7:0];
                  OP_SETI: index_ff <= op_ff[11:0];
                  OP_DRAW: begin
                     x0_ff   <= CX_W'(vreg_ff[op_ff[11:8]] % 8'(DISPLAY_WIDTH));
                     y_ff    <= RY_W'(vreg_ff[op_ff[7:4]] % 8'(DISPLAY_HEIGHT));
                     left_ff <= op_ff[3:0];
                     sa_ff   <= index_ff;
                     vreg_ff[15] <= 8'h00;
                  end
                  default: ;
               endcase
            end
            CMD_CLEAR_ROW: begin
               fvalid_ff[cnt_ff[RY_W-1:0]] <= 1'b0;
               cnt_ff <= cnt_ff + 1'b1;
            end
            CMD_DRAW_READ: sa_ff <= sa_ff + 12'd1;
            CMD_DRAW_WRITE: begin
               fvalid_ff[y_ff] <= 1'b1;
               if ((cur_row & spr_mask) != '0) vreg_ff[15] <= 8'h01;
               y_ff    <= y_ff + 1'b1;
               left_ff <= left_ff - 4'd1;
            end
            CMD_RESPOND: rsp_valid <= 1'b1;
            default: ;
         endcase
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_RESPOND) begin
         rsp_status         <= ctl.status;
         rsp_fetched_opcode <= op_ff;
         rsp_next_pc        <= pc_ff;
         rsp_collision      <= vreg_ff[15][0];
         rsp_row_bits       <= (act_ff == ACT_ROW && fvalid_ff[addr_ff[RY_W-1:0]] &&
                                {1'b0, addr_ff} < 13'(DISPLAY_HEIGHT))
                               ? (frow_ff & COL_MASK) : '0;
      end
   end
endmodule

/* rtl/chip8_instruction_core.sv */
// Top level of the CHIP-8 instruction core (subset).
// Depends on c8ic_pkg, c8ic_controller and c8ic_datapath.
//
// Usage: raise start with req_action/req_address/req_data while busy is low;
// the item is taken at that edge. Exactly one result follows: rsp_valid is
// high for one cycle with rsp_status, rsp_fetched_opcode, rsp_next_pc,
// rsp_collision and rsp_row_bits. The receiver cannot hold results off.
// An instruction is fetched as two bytes through the one read port of the
// program memory; clear screen steps through every display row, and a sprite
// draw does a frame row read-modify-write for each drawn row.
// csr_write/csr_data load the start address into the program counter;
// write only while busy is low.
// Reset is synchronous: registers clear, the program counter takes 0x200,
// and a clearing pass loads font and zeros into program memory; busy stays
// high through that pass.
module chip8_instruction_core #(
   parameter int DISPLAY_WIDTH  = c8ic_pkg::DisplayWidthDefault,
   parameter int DISPLAY_HEIGHT = c8ic_pkg::DisplayHeightDefault,
   parameter int MEM_DEPTH      = c8ic_pkg::MemDepthDefault,
   parameter int STACK_DEPTH    = c8ic_pkg::StackDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_data,
   input  logic        csr_write,
   input  logic [11:0] csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_fetched_opcode,
   output logic [11:0] rsp_next_pc,
   output logic        rsp_collision,
   output logic [63:0] rsp_row_bits
);
   import c8ic_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic    ctl_busy, init_busy_ff;

   // hold off items during the memory clearing pass
   logic [$clog2(MEM_DEPTH):0] init_cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         init_busy_ff <= 1'b1;
         init_cnt_ff  <= '0;
      end else if (init_busy_ff) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
         if (init_cnt_ff == ($clog2(MEM_DEPTH)+1)'(MEM_DEPTH - 1)) init_busy_ff <= 1'b0;
      end
   end

   assign busy = ctl_busy | init_busy_ff;

   c8ic_controller u_ctl (
      .clock  (clock),
      .reset  (reset),
      .start  (start & ~init_busy_ff),
      .action (req_action),
      .sts    (sts),
      .ctl    (ctl),
      .busy   (ctl_busy)
   );

   c8ic_datapath #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
      .MEM_DEPTH      (MEM_DEPTH),
      .STACK_DEPTH    (STACK_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_address        (req_address),
      .req_data           (req_data),
      .csr_write          (csr_write),
      .csr_data           (csr_data),
      .ctl                (ctl),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_fetched_opcode (rsp_fetched_opcode),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_collision      (rsp_collision),
      .rsp_row_bits       (rsp_row_bits)
   );
endmodule

/* dv/testbench.sv */
// Self-checking testbench for chip8_instruction_core: directed table, then random programs.
// Results come from a shadow model or a typed table row and are compared field by field.
// Depends on c8ic_pkg and the core RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import c8ic_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 48;
   localparam int RANDOM_ITEMS = 260;
   localparam int NUM_PHASES = 5;
   localparam int WIDTH = DisplayWidthDefault;
   localparam int HEIGHT = DisplayHeightDefault;
   localparam int DEPTH = StackDepthDefault;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] opcode;
      logic [11:0] pc;
      logic        coll;
      logic [63:0] row;
   } core_result_t;

   typedef struct {
      logic [1:0]  act;
      logic [11:0] addr;
      logic [7:0]  data;
      int          reps;
      bit          typed;
      logic [1:0]  status;
      logic [15:0] opcode;
      logic [11:0] pc;
      logic        coll;
   } plan_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_action = '0;
   logic [11:0] req_address = '0;
   logic [7:0]  req_data = '0;
   logic        csr_write = 1'b0;
   logic [11:0] csr_data = '0;
   logic        busy, rsp_valid, rsp_collision;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_fetched_opcode;
   logic [11:0] rsp_next_pc;
   logic [63:0] rsp_row_bits;

   // typed expectation travels with the item it belongs to
   bit           typed_on = 1'b0;
   core_result_t typed_result = '{default: '0};

   bit failed = 1'b0;
   int cycles = 0;
   int quiet_left = 0;
   core_result_t expected_results[$];

   // shadow state of the core
   logic [7:0]  prog_mem [4096];
   logic [63:0] frame [HEIGHT];
   logic [11:0] ret_stack [DEPTH];
   int          stack_lvl;
   logic [7:0]  vreg [16];
   logic [11:0] index_reg;
   logic [11:0] pc_reg;

   localparam logic [7:0] GLYPHS [80] = '{
      8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
      8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
      8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
      8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
      8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
      8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
      8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
      8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};

   plan_row_t plan [21] = '{
      '{ACT_ROW,   12'h000, 8'h00, 1, 1, ST_OK,        16'h0000, 12'h200, 1'b0},
      '{ACT_NONE,  12'hFFF, 8'hFF, 1, 1, ST_OK,        16'h0000, 12'h200, 1'b0},
      '{ACT_EXEC,  12'h000, 8'h00, 1, 1, ST_UNIMPL,    16'h0000, 12'h202, 1'b0},
      '{ACT_WRITE, 12'h202, 8'h00, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_WRITE, 12'h203, 8'hEE, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_EXEC,  12'h000, 8'h00, 1, 1, ST_UNDERFLOW, 16'h00EE, 12'h204, 1'b0},
      '{ACT_WRITE, 12'h204, 8'hD0, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_WRITE, 12'h205, 8'h15, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_EXEC,  12'h000, 8'h00, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_ROW,   12'h000, 8'h00, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_WRITE, 12'h206, 8'hD0, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_WRITE, 12'h207, 8'h15, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_EXEC,  12'h000, 8'h00, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_ROW,   12'h000, 8'h00, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_ROW,   12'h01F, 8'h00, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_ROW,   12'h020, 8'h00, 1, 1, ST_OK,        16'h0000, 12'h208, 1'b1},
      '{ACT_ROW,   12'hFFF, 8'h00, 1, 1, ST_OK,        16'h0000, 12'h208, 1'b1},
      '{ACT_WRITE, 12'hFFF, 8'hFF, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      // call to itself until the return stack overflows
      '{ACT_WRITE, 12'h208, 8'h22, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_WRITE, 12'h209, 8'h08, 1, 0, ST_OK,        16'h0000, 12'h000, 1'b0},
      '{ACT_EXEC,  12'h000, 8'h00, 17, 0, ST_OK,       16'h0000, 12'h000, 1'b0}};

   chip8_instruction_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_address(req_address), .req_data(req_data),
      .csr_write(csr_write), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_fetched_opcode(rsp_fetched_opcode), .rsp_next_pc(rsp_next_pc),
      .rsp_collision(rsp_collision), .rsp_row_bits(rsp_row_bits));

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // load the power-on state of the shadow core
   function automatic void core_power_on();
      for (int a = 0; a < 4096; a++) prog_mem[a] = (a < 80) ? GLYPHS[a] : 8'h00;
      for (int r = 0; r < HEIGHT; r++) frame[r] = '0;
      for (int k = 0; k < 16; k++) vreg[k] = '0;
      stack_lvl = 0;
      index_reg = '0;
      pc_reg = RESET_START;
   endfunction

   // advance the shadow core by one item and return what the core should report
   function automatic core_result_t core_step(logic [1:0] act, logic [11:0] adr,
                                               logic [7:0] dat);
      core_result_t r;
      logic [15:0] op;
      logic [11:0] nnn;
      logic [11:0] src;
      logic [7:0]  bits;
      int px, py, col;
      logic hit;
      r = '{default: '0};
      op = '0;
      case (act)
         ACT_WRITE: prog_mem[adr] = dat;
         ACT_EXEC: begin
            op = {prog_mem[pc_reg], prog_mem[pc_reg + 12'd1]};
            pc_reg = pc_reg + 12'd2;
            nnn = op[11:0];
            r.status = ST_OK;
            case (op[15:12])
               OP_SYS: begin
                  if (nnn == NNN_CLS) begin
                     for (int k = 0; k < HEIGHT; k++) frame[k] = '0;
                  end else if (nnn == NNN_RET) begin
                     if (stack_lvl == 0) r.status = ST_UNDERFLOW;
                     else begin
                        stack_lvl--;
                        pc_reg = ret_stack[stack_lvl];
                     end
                  end else r.status = ST_UNIMPL;
               end
               OP_CALL: begin
                  if (stack_lvl >= DEPTH) r.status = ST_OVERFLOW;
                  else begin
                     ret_stack[stack_lvl] = pc_reg;
                     stack_lvl++;
                     pc_reg = nnn;
                  end
               end
               OP_SETV: vreg[op[11:8]] = op[7:0];
               OP_SETI: index_reg = nnn;
               OP_DRAW: begin
                  // take coordinates before clearing the flag register
                  px = vreg[op[11:8]] % WIDTH;
                  py = vreg[op[7:4]] % HEIGHT;
                  vreg[15] = '0;
                  hit = 1'b0;
                  for (int i = 0; i < op[3:0] && py < HEIGHT; i++, py++) begin
                     src = index_reg + 12'(i);
                     bits = prog_mem[src];
                     for (int j = 0; j < 8; j++) begin
                        col = px + j;
                        if (col >= WIDTH) break;
                        if (bits[7-j]) begin
                           if (frame[py][63-col]) hit = 1'b1;
                           frame[py][63-col] = ~frame[py][63-col];
                        end
                     end
                  end
                  if (hit) vreg[15] = 8'd1;
               end
               default: r.status = ST_UNIMPL;
            endcase
         end
         ACT_ROW: if (adr < HEIGHT) r.row = frame[adr];
         default: ;
      endcase
      r.opcode = op;
      r.pc = pc_reg;
      r.coll = vreg[15][0];
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
         failed = 1'b1;
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, got_v);
      end
   endtask

   // check results, track register writes, predict accepted items
   always @(posedge clock) begin
      core_result_t want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               failed = 1'b1;
               $display("%0t: unexpected result, expected none, actual status %h pc %h",
                        $realtime, rsp_status, rsp_next_pc);
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("opcode", want.opcode, rsp_fetched_opcode);
               check_field("next_pc", want.pc, rsp_next_pc);
               check_field("collision", want.coll, rsp_collision);
               check_field("row_bits", want.row, rsp_row_bits);
            end
         end
         if (csr_write) pc_reg = csr_data;
         if (start && !busy) begin
            want = core_step(req_action, req_address, req_data);
            expected_results.push_back(typed_on ? typed_result : want);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // present one item after a random gap and hold it until busy reads low after an edge
   task automatic send_item(logic [1:0] act, logic [11:0] adr, logic [7:0] dat,
                            bit typed = 1'b0, core_result_t tr = '{default: '0});
      int gap, r;
      gap = 0;
      if (quiet_left > 0) quiet_left--;
      else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(20, 60);
      else begin
         r = $urandom_range(0, 99);
         if (r >= 93) gap = $urandom_range(5, 40);
         else if (r >= 65) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_address <= adr;
      req_data <= dat;
      typed_on <= typed;
      typed_result <= tr;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // drain outstanding results, then let the core settle
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_start_address(logic [11:0] value);
      wait_idle();
      csr_write <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [15:0] random_opcode(int call_weight);
      int r;
      logic [11:0] nnn;
      r = $urandom_range(0, 99);
      nnn = ($urandom_range(0, 1) == 1) ? 12'($urandom_range(0, 79)) : 12'($urandom);
      if (r < 22) return {OP_SETV, 4'($urandom), 8'($urandom)};
      if (r < 35) return {OP_SETI, nnn};
      if (r < 60) return {OP_DRAW, 12'($urandom)};
      if (r < 63) return {OP_SYS, NNN_CLS};
      if (r < 63 + call_weight) return {OP_CALL, 12'($urandom)};
      if (r < 63 + 2 * call_weight) return {OP_SYS, NNN_RET};
      return 16'($urandom);
   endfunction

   initial begin
      core_result_t tr;
      logic [15:0] op;
      logic [11:0] at;
      int sent, r, call_weight;
      core_power_on();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (plan[n]) begin
         tr = '{plan[n].status, plan[n].opcode, plan[n].pc, plan[n].coll, 64'd0};
         repeat (plan[n].reps)
            send_item(plan[n].act, plan[n].addr, plan[n].data, plan[n].typed, tr);
      end

      // random programs under several start addresses
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: write_start_address(12'hFFF);
            1: write_start_address(12'h000);
            4: write_start_address(RESET_START);
            default: write_start_address(12'($urandom));
         endcase
         call_weight = (ph % 2 == 1) ? 12 : 4;
         sent = 0;
         while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               // store an opcode at the program counter, then run it
               op = random_opcode(call_weight);
               at = pc_reg;
               send_item(ACT_WRITE, at, op[15:8]);
               send_item(ACT_WRITE, at + 12'd1, op[7:0]);
               send_item(ACT_EXEC, 12'($urandom), 8'($urandom));
               sent += 3;
            end else if (r < 85) begin
               at = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
               send_item(ACT_ROW, at, 8'($urandom));
               sent++;
            end else if (r < 95) begin
               send_item(2'($urandom_range(0, 3)), 12'($urandom), 8'($urandom));
               sent++;
            end else begin
               send_item(ACT_EXEC, 12'($urandom), 8'($urandom));
               sent++;
            end
         end
      end

      wait_idle();
      if (!failed) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
